FILE: rtl/sre_pkg.sv
// shared constants and width helpers for the signed rice encoder
package sre_pkg;

   localparam int DefaultMaxCode   = 24;
   localparam int DefaultValueBits = 12;
   localparam int LowBits          = 7;
   localparam int ByteBits         = 8;
   localparam int QueueDepth       = 4;

   // region codes carried on stream_sel
   localparam logic SelLow    = 1'b0;
   localparam logic SelStream = 1'b1;

   // bits needed for a stream bit position (offset plus largest legal code)
   function automatic int pos_width(input int max_code);
      return $clog2(max_code + 8);
   endfunction

   // bits for a full-byte count or a byte index within one word's run
   function automatic int nfull_width(input int max_code);
      return pos_width(max_code) - 2;
   endfunction

   // bits for the result step counter of one word
   function automatic int step_width(input int max_code);
      return pos_width(max_code) - 1;
   endfunction

endpackage

FILE: rtl/sre_front.sv
// front end: maps each value to its rice code and advances the stream state
module sre_front #(
   parameter int  MAX_CODE   = sre_pkg::DefaultMaxCode,
   parameter int  VALUE_BITS = sre_pkg::DefaultValueBits,
   parameter type job_type   = logic
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic signed [VALUE_BITS-1:0] value,
   input  logic                         final_item,
   output job_type                      job
);
   import sre_pkg::*;

   localparam int HiW    = VALUE_BITS - LowBits;
   localparam int HpW    = HiW + 1;
   localparam int CodeW  = HpW + 1;
   localparam int PosW   = pos_width(MAX_CODE);
   localparam int NfullW = nfull_width(MAX_CODE);

   logic [ByteBits-1:0] partial_ff, partial_in;
   logic [2:0]          offset_ff, offset_in;

   logic signed [HiW-1:0] high_part;
   logic signed [HpW-1:0] hp_ext, hp;
   logic [HpW-1:0]        mag;
   logic [CodeW-1:0]      code;
   logic [31:0]           code32;
   logic                  err;
   logic [PosW-1:0]       pos;
   logic [PosW:0]         pos_inc;
   logic [NfullW-1:0]     nfull;
   logic [ByteBits-1:0]   one_byte, partial_new;
   logic [2:0]            offset_new;

   always_comb begin
      high_part = value[VALUE_BITS-1:LowBits];
      hp_ext    = {high_part[HiW-1], high_part};
      // low part negative: high part plus one, else negated
      if (value[LowBits-1]) begin
         hp = hp_ext + HpW'(1);
      end else begin
         hp = -hp_ext;
      end
      mag    = hp[HpW-1] ? HpW'(-hp) : HpW'(hp);
      code   = {mag, 1'b0} - CodeW'(hp[HpW-1]);
      code32 = {{(32-CodeW){1'b0}}, code};
      err    = code32 > 32'(MAX_CODE);

      pos      = PosW'(offset_ff) + code32[PosW-1:0];
      pos_inc  = {1'b0, pos} + (PosW+1)'(1);
      one_byte = ByteBits'(1) << pos[2:0];

      if (err) begin
         nfull       = '0;
         partial_new = partial_ff;
         offset_new  = offset_ff;
      end else begin
         nfull      = pos_inc[PosW:3];
         offset_new = pos_inc[2:0];
         if (nfull == '0) begin
            partial_new = partial_ff | one_byte;
         end else if (offset_new != 3'd0) begin
            partial_new = one_byte;
         end else begin
            partial_new = '0;
         end
      end

      job            = '0;
      job.low7       = value[LowBits-1:0];
      job.err        = err;
      job.last       = final_item;
      job.nfull      = nfull;
      job.hi_idx     = NfullW'(pos[PosW-1:3]);
      job.first_byte = (pos[PosW-1:3] == '0) ? (partial_ff | one_byte) : partial_ff;
      job.one_byte   = one_byte;
      job.flush      = final_item && (offset_new != 3'd0);
      job.flush_byte = partial_new;

      partial_in = partial_ff;
      offset_in  = offset_ff;
      if (accept) begin
         partial_in = final_item ? '0 : partial_new;
         offset_in  = final_item ? 3'd0 : offset_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         offset_ff  <= '0;
      end else begin
         partial_ff <= partial_in;
         offset_ff  <= offset_in;
      end
   end

endmodule

FILE: rtl/sre_queue.sv
// short job queue between the front end and the result sequencer
module sre_queue #(
   parameter type job_type = logic
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head_job,
   output logic    empty
);
   import sre_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   job_type         entry_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   always_comb begin
      full      = count_ff == CntW'(QueueDepth);
      empty     = count_ff == '0;
      head_job  = entry_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/sre_back.sv
// back end: steps through the result words of each job into an output register
module sre_back #(
   parameter int  MAX_CODE = sre_pkg::DefaultMaxCode,
   parameter type job_type = logic
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  job_type                      job,
   output logic                         job_done,
   output logic                         out_empty,
   input  logic                         out_pop,
   output logic                         out_stream_sel,
   output logic [sre_pkg::ByteBits-1:0] out_data_byte,
   output logic                         out_code_error,
   output logic                         out_run_last,
   output logic                         out_vector_done
);
   import sre_pkg::*;

   localparam int NfullW = nfull_width(MAX_CODE);
   localparam int StepW  = step_width(MAX_CODE);

   logic [StepW-1:0]    step_ff, step_in;
   logic                valid_ff, valid_in;
   logic                sel_ff, sel_in;
   logic [ByteBits-1:0] data_ff, data_in;
   logic                err_ff, err_in;
   logic                run_last_ff, run_last_in;
   logic                done_ff, done_in;

   logic                advance, last_step, in_stream;
   logic [StepW-1:0]    idx, last_idx;
   logic [NfullW-1:0]   byte_idx;

   always_comb begin
      advance   = job_valid && (!valid_ff || out_pop);
      last_idx  = StepW'(job.nfull) + StepW'(job.flush);
      last_step = step_ff == last_idx;
      in_stream = (step_ff != '0) && (step_ff <= StepW'(job.nfull));
      idx       = step_ff - StepW'(1);
      byte_idx  = idx[NfullW-1:0];
      job_done  = advance && last_step;

      sel_in      = sel_ff;
      data_in     = data_ff;
      err_in      = err_ff;
      run_last_in = run_last_ff;
      done_in     = done_ff;
      step_in     = step_ff;
      valid_in    = valid_ff && !out_pop;

      if (advance) begin
         valid_in    = 1'b1;
         err_in      = job.err;
         run_last_in = last_step;
         done_in     = last_step && job.last;
         step_in     = last_step ? '0 : step_ff + StepW'(1);
         if (step_ff == '0) begin
            sel_in  = SelLow;
            data_in = {1'b0, job.low7};
         end else if (in_stream) begin
            sel_in = SelStream;
            if (byte_idx == '0) begin
               data_in = job.first_byte;
            end else if (byte_idx == job.hi_idx) begin
               data_in = job.one_byte;
            end else begin
               data_in = '0;
            end
         end else begin
            sel_in  = SelStream;
            data_in = job.flush_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      sel_ff      <= sel_in;
      data_ff     <= data_in;
      err_ff      <= err_in;
      run_last_ff <= run_last_in;
      done_ff     <= done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   assign out_empty       = !valid_ff;
   assign out_stream_sel  = sel_ff;
   assign out_data_byte   = data_ff;
   assign out_code_error  = err_ff;
   assign out_run_last    = run_last_ff;
   assign out_vector_done = done_ff;

endmodule

FILE: rtl/signed_rice_k7_encoder.sv
// top level of the signed rice encoder with a seven-bit low part
//
// usage
//   input side is a queue: drive req_value and req_final_item with req_push;
//   a word is taken at a clock edge with req_push high and req_full low
//   result side is a queue: while rsp_empty is low the oldest result word is
//   on the rsp_ ports; rsp_pop high at a clock edge takes it
//   each input word gives its low-part byte first (stream_sel 0), then any
//   completed stream bytes, then the flushed partial byte on a final item;
//   run_last marks the last word of an input, vector_done that of the vector
// timing
//   front end takes one input word per cycle while the four-entry job queue
//   has room; the back end emits one result word per cycle while the receiver
//   pops and a job waits, and an input gives 1 + full stream bytes (+1 on flush)
//   result words, usually one or two, at most 1 + (MAX_CODE + 15) / 8, five at the default limit
//   the first result word of an input passes the job queue, then the output register
// reset clears the stream state and the job queue and empties the output register
// a stalled receiver holds the output word; the queue then fills and
// req_full rises, nothing is lost
module signed_rice_k7_encoder #(
   parameter int MAX_CODE   = sre_pkg::DefaultMaxCode,
   parameter int VALUE_BITS = sre_pkg::DefaultValueBits
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         req_final_item,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic                         rsp_stream_sel,
   output logic [sre_pkg::ByteBits-1:0] rsp_data_byte,
   output logic                         rsp_code_error,
   output logic                         rsp_run_last,
   output logic                         rsp_vector_done
);
   import sre_pkg::*;

   localparam int NfullW = nfull_width(MAX_CODE);

   // one classified input word, as it waits for the sequencer
   typedef struct packed {
      logic [LowBits-1:0]  low7;
      logic                err;
      logic                last;
      logic [NfullW-1:0]   nfull;       // completed stream bytes
      logic [NfullW-1:0]   hi_idx;      // byte holding the terminating one
      logic [ByteBits-1:0] first_byte;  // old partial byte merged with new bits
      logic [ByteBits-1:0] one_byte;    // terminating one in its byte
      logic                flush;
      logic [ByteBits-1:0] flush_byte;
   } job_type;

   job_type front_job, head_job;
   logic    accept, q_full, q_empty, job_done;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   // classification and stream state update, one word per cycle while the queue has room
   sre_front #(
      .MAX_CODE   (MAX_CODE),
      .VALUE_BITS (VALUE_BITS),
      .job_type   (job_type)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .value      (req_value),
      .final_item (req_final_item),
      .job        (front_job)
   );

   // decouples the front end from a stalled result side
   sre_queue #(
      .job_type (job_type)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_job (front_job),
      .full     (q_full),
      .pop      (job_done),
      .head_job (head_job),
      .empty    (q_empty)
   );

   // result sequencer with the output register
   sre_back #(
      .MAX_CODE (MAX_CODE),
      .job_type (job_type)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (!q_empty),
      .job             (head_job),
      .job_done        (job_done),
      .out_empty       (rsp_empty),
      .out_pop         (rsp_pop),
      .out_stream_sel  (rsp_stream_sel),
      .out_data_byte   (rsp_data_byte),
      .out_code_error  (rsp_code_error),
      .out_run_last    (rsp_run_last),
      .out_vector_done (rsp_vector_done)
   );

   // end of vector always closes the run of its input
   a_done_closes_run: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_vector_done) |-> rsp_run_last)
      else $error("vector_done without run_last");

   // the rest of a run follows at once and always lies in the stream region
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_run_last) |=>
      (!rsp_empty && rsp_stream_sel == SelStream))
      else $error("run broken or continued in low-part region");

   // a new run always opens with a low-part byte
   a_run_opens_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && rsp_run_last) |=>
      (rsp_empty || rsp_stream_sel == SelLow))
      else $error("run did not open with its low-part byte");

   // reset leaves no result pending
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("result or full flag survived reset");

endmodule
